FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/bpc_pkg.sv
// Types and constants for the button press classifier.
// No dependencies; imported by every other file of the block but assert_macros.svh.
package bpc_pkg;

   localparam int IntervalW = 8;
   localparam int LenW      = 10;
   localparam int CsrAddrW  = 4;
   localparam int CsrDataW  = 32;

   localparam logic [LenW-1:0]      LEN_MAX          = 10'd1023;
   localparam logic [IntervalW-1:0] INTERVAL_RESET   = 8'd2;
   localparam logic [LenW-1:0]      LONG_THRESH_RESET = 10'd15;
   localparam logic [LenW-1:0]      HOLD_THRESH_RESET = 10'd50;

   typedef enum logic [2:0] {
      EV_NONE         = 3'd0,
      EV_FAST         = 3'd1,
      EV_SHORT        = 3'd2,
      EV_LONG         = 3'd3,
      EV_HOLD_RELEASE = 3'd4
   } event_type;

   typedef enum logic [1:0] {
      REG_INTERVAL = 2'd0,
      REG_LONG     = 2'd1,
      REG_HOLD     = 2'd2
   } reg_idx_type;

   typedef struct packed {
      logic [IntervalW-1:0] sample_interval;
      logic [LenW-1:0]      long_threshold;
      logic [LenW-1:0]      hold_threshold;
   } cfg_type;

   typedef struct packed {
      event_type event_res;
      logic      holding;
   } result_type;

endpackage

FILE: hw/rtl/bpc_if.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on bpc_pkg for the event type.
interface bpc_req_if;
   logic valid;
   logic ready;
   logic pressed;

   modport source (output valid, output pressed, input ready);
   modport sink   (input valid, input pressed, output ready);
endinterface

interface bpc_rsp_if import bpc_pkg::*;;
   logic      valid;
   logic      ready;
   event_type event_res;
   logic      holding;

   modport source (output valid, output event_res, output holding, input ready);
   modport sink   (input valid, input event_res, input holding, output ready);
endinterface

FILE: hw/rtl/bpc_csr.sv
// APB-style register file: sample interval, long and hold thresholds.
// Depends on bpc_pkg.
module bpc_csr import bpc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CsrAddrW-1:0] paddr,
   input  logic [CsrDataW-1:0] pwdata,
   output logic [CsrDataW-1:0] prdata,
   output logic                pready,
   output cfg_type             cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type reg_idx;
   logic        wr_en;

   assign reg_idx = reg_idx_type'(paddr[3:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_INTERVAL: cfg_in.sample_interval = pwdata[IntervalW-1:0];
            REG_LONG:     cfg_in.long_threshold  = pwdata[LenW-1:0];
            REG_HOLD:     cfg_in.hold_threshold  = pwdata[LenW-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_INTERVAL: prdata = {{(CsrDataW-IntervalW){1'b0}}, cfg_ff.sample_interval};
         REG_LONG:     prdata = {{(CsrDataW-LenW){1'b0}}, cfg_ff.long_threshold};
         REG_HOLD:     prdata = {{(CsrDataW-LenW){1'b0}}, cfg_ff.hold_threshold};
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_interval <= INTERVAL_RESET;
         cfg_ff.long_threshold  <= LONG_THRESH_RESET;
         cfg_ff.hold_threshold  <= HOLD_THRESH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hw/rtl/bpc_step.sv
// Debounce and press classification state, advanced one sample per step.
// Depends on bpc_pkg.
module bpc_step import bpc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic       pressed,
   input  cfg_type    cfg,
   output result_type result
);

   logic                 idle_ff, idle_in;
   logic [IntervalW-1:0] cd_ff, cd_in;
   logic                 conf_ff, conf_in;
   logic                 rel_ff, rel_in;
   logic [LenW-1:0]      len_ff, len_in;
   logic                 long_ff, long_in;
   logic                 hold_ff, hold_in;
   logic [IntervalW-1:0] cd_dec;
   logic [LenW-1:0]      len_inc;
   logic                 proceed;
   event_type            ev;

   assign cd_dec  = (idle_ff ? cfg.sample_interval : cd_ff) - 8'd1;
   assign len_inc = (len_ff < LEN_MAX) ? len_ff + 10'd1 : len_ff;

   always_comb begin
      idle_in = idle_ff;
      cd_in   = cd_ff;
      conf_in = conf_ff;
      rel_in  = rel_ff;
      len_in  = len_ff;
      long_in = long_ff;
      hold_in = hold_ff;
      ev      = EV_NONE;
      proceed = 1'b0;
      if (step_en && (!idle_ff || pressed)) begin
         idle_in = 1'b0;
         cd_in   = cd_dec;
         if (cd_dec == '0) begin
            proceed = 1'b1;
            if (!conf_ff) begin
               if (pressed) begin
                  conf_in = 1'b1;
                  ev      = EV_FAST;
               end else begin
                  // press not confirmed: drop back to idle silently
                  idle_in = 1'b1;
                  rel_in  = 1'b0;
                  conf_in = 1'b0;
                  proceed = 1'b0;
               end
            end
            if (proceed) begin
               if (!rel_ff) begin
                  cd_in = cfg.sample_interval;
                  if (pressed) begin
                     len_in = len_inc;
                     if (len_inc >= cfg.long_threshold && len_inc < cfg.hold_threshold) begin
                        long_in = 1'b1;
                     end
                     if (len_inc >= cfg.hold_threshold) begin
                        hold_in = 1'b1;
                     end
                  end else begin
                     rel_in = 1'b1;
                  end
               end else begin
                  priority if (hold_ff) begin
                     ev      = EV_HOLD_RELEASE;
                     hold_in = 1'b0;
                  end else if (long_ff) begin
                     ev = EV_LONG;
                  end else begin
                     ev = EV_SHORT;
                  end
                  long_in = 1'b0;
                  len_in  = '0;
                  idle_in = 1'b1;
                  rel_in  = 1'b0;
                  conf_in = 1'b0;
               end
            end
         end
      end
   end

   assign result.event_res = ev;
   assign result.holding   = hold_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff <= 1'b1;
         cd_ff   <= INTERVAL_RESET;
         conf_ff <= 1'b0;
         rel_ff  <= 1'b0;
         len_ff  <= '0;
         long_ff <= 1'b0;
         hold_ff <= 1'b0;
      end else begin
         idle_ff <= idle_in;
         cd_ff   <= cd_in;
         conf_ff <= conf_in;
         rel_ff  <= rel_in;
         len_ff  <= len_in;
         long_ff <= long_in;
         hold_ff <= hold_in;
      end
   end

endmodule

FILE: hw/rtl/button_press_classifier.sv
// Throughput: one word per cycle while the response channel is not stalled; the classifier
// state is advanced between the input register and the response register.
// Reset: synchronous, active high; clears the classifier state and both valid flags
// and loads the CSR defaults; the payload registers are not reset.
// Depends on bpc_pkg, bpc_if, bpc_csr and bpc_step.
module button_press_classifier import bpc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   bpc_req_if.sink             req_ch,
   bpc_rsp_if.source           rsp_ch,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CsrAddrW-1:0] paddr,
   input  logic [CsrDataW-1:0] pwdata,
   output logic [CsrDataW-1:0] prdata,
   output logic                pready
);

   cfg_type    cfg;
   result_type step_res;
   logic       in_vld_ff, in_vld_in;
   logic       in_pressed_ff;
   logic       out_vld_ff, out_vld_in;
   result_type out_res_ff;
   logic       out_free;
   logic       advance;
   logic       req_take;

   bpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bpc_step u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .pressed (in_pressed_ff),
      .cfg     (cfg),
      .result  (step_res)
   );

   assign out_free     = !out_vld_ff || rsp_ch.ready;
   assign advance      = in_vld_ff && out_free;
   assign req_ch.ready = !in_vld_ff || out_free;
   assign req_take     = req_ch.valid && req_ch.ready;

   assign in_vld_in  = req_take || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && !rsp_ch.ready);

   assign rsp_ch.valid     = out_vld_ff;
   assign rsp_ch.event_res = out_res_ff.event_res;
   assign rsp_ch.holding   = out_res_ff.holding;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // hold payloads while stalled
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_pressed_ff <= req_ch.pressed;
      end
      if (advance) begin
         out_res_ff <= step_res;
      end
   end

endmodule

FILE: hw/rtl/bpc_checker.sv
// Port-level assertions for the button press classifier, bound to the top level.
// Depends on bpc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bpc_checker import bpc_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input event_type rsp_event_res,
   input logic      rsp_holding,
   input logic      pready
);

   `ASSERT_CLK(a_rsp_empty_after_reset, clock,
      reset |=> !rsp_valid, "response valid right after reset")
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid, "response word dropped while stalled")
   `ASSERT_CLK_RST(a_event_range, clock, reset,
      rsp_valid |-> rsp_event_res <= EV_HOLD_RELEASE, "event code out of range")
   `ASSERT_CLK_RST(a_hold_cleared, clock, reset,
      rsp_valid && rsp_event_res == EV_HOLD_RELEASE |-> !rsp_holding,
      "hold flag still set on release after hold")
   `ASSERT_CLK_RST(a_pready_high, clock, reset, pready, "register port not ready")

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_event_res (rsp_ch.event_res),
   .rsp_holding   (rsp_ch.holding),
   .pready        (pready)
);
